@@ hw/rtl/ipdfe_pkg.sv @@
// Shared types and constants for the pulse-distance IR frame encoder.
// No dependencies; imported by every module of the block.
package ipdfe_pkg;

    localparam int DUR_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_W       = 3;
    localparam int WAKE_SYMBOLS = 5;
    localparam int MAX_WAKE    = 6;
    localparam int WAKE_COUNT  = (WAKE_SYMBOLS > MAX_WAKE) ? MAX_WAKE : WAKE_SYMBOLS;
    localparam logic [CNT_W-1:0] WAKE_LAST = CNT_W'(WAKE_COUNT - 1);
    localparam logic [CNT_W-1:0] BIT_LAST  = '1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        K_WAKE    = 3'd0,
        K_TRAILER = 3'd1,
        K_HEADER  = 3'd2,
        K_DATA    = 3'd3,
        K_CHECK   = 3'd4,
        K_END     = 3'd5
    } symbol_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_MARK   = 3'd0,
        CFG_HEADER_SPACE  = 3'd1,
        CFG_BIT_MARK      = 3'd2,
        CFG_ONE_SPACE     = 3'd3,
        CFG_SHORT_MARK    = 3'd4,
        CFG_ZERO_SPACE    = 3'd5,
        CFG_TRAILER_SPACE = 3'd6,
        CFG_GAP_SPACE     = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAKE,
        PH_TRAILER,
        PH_HEADER,
        PH_DATA,
        PH_CHECK,
        PH_END
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_frame;
        logic       end_of_frame;
        logic       second_frame;
    } in_item_t;

    typedef struct packed {
        logic [DUR_W-1:0] mark_ticks;
        logic [DUR_W-1:0] space_ticks;
        symbol_kind_t     symbol_kind;
        logic             last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark;
        logic [DUR_W-1:0] header_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] short_mark;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] wake_trailer_space;
        logic [DUR_W-1:0] gap_space;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] checksum;
        logic       start_of_frame;
        logic       end_of_frame;
        logic       second_frame;
    } cmd_t;

endpackage

@@ hw/rtl/ipdfe_cfg.sv @@
// Timing register file of the IR frame encoder.
// Depends on ipdfe_pkg.
module ipdfe_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ipdfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipdfe_pkg::DUR_W-1:0]   cfg_data,
    output ipdfe_pkg::cfg_t               cfg
);
    import ipdfe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEADER_MARK:   cfg_next.header_mark        = cfg_data;
                CFG_HEADER_SPACE:  cfg_next.header_space       = cfg_data;
                CFG_BIT_MARK:      cfg_next.bit_mark           = cfg_data;
                CFG_ONE_SPACE:     cfg_next.one_space          = cfg_data;
                CFG_SHORT_MARK:    cfg_next.short_mark         = cfg_data;
                CFG_ZERO_SPACE:    cfg_next.zero_space         = cfg_data;
                CFG_TRAILER_SPACE: cfg_next.wake_trailer_space = cfg_data;
                CFG_GAP_SPACE:     cfg_next.gap_space          = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark        <= DUR_W'(3650);
            cfg_reg.header_space       <= DUR_W'(1623);
            cfg_reg.bit_mark           <= DUR_W'(428);
            cfg_reg.one_space          <= DUR_W'(1280);
            cfg_reg.short_mark         <= DUR_W'(428);
            cfg_reg.zero_space         <= DUR_W'(428);
            cfg_reg.wake_trailer_space <= DUR_W'(25000);
            cfg_reg.gap_space          <= DUR_W'(29000);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/ipdfe_front.sv @@
// Front end: takes payload beats, keeps the frame checksum, builds commands.
// Depends on ipdfe_pkg.
module ipdfe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ipdfe_pkg::in_item_t in_data,
    output logic                push,
    output ipdfe_pkg::cmd_t     push_cmd,
    input  logic                q_ready
);
    import ipdfe_pkg::*;

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] sum_base;
    logic [7:0] frame_sum;

    assign in_ready  = q_ready;
    assign push      = in_valid && q_ready;
    assign sum_base  = in_data.start_of_frame ? 8'd0 : running_sum_reg;
    assign frame_sum = sum_base + in_data.data_byte;

    always_comb
    begin
        push_cmd.data_byte      = in_data.data_byte;
        push_cmd.checksum       = frame_sum;
        push_cmd.start_of_frame = in_data.start_of_frame;
        push_cmd.end_of_frame   = in_data.end_of_frame;
        push_cmd.second_frame   = in_data.second_frame;
    end

    always_comb
    begin
        running_sum_next = running_sum_reg;
        if (push)
        begin
            running_sum_next = in_data.end_of_frame ? 8'd0 : frame_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= 8'd0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

@@ hw/rtl/ipdfe_queue.sv @@
// Short command queue between front end and symbol sequencer.
// Depends on ipdfe_pkg.
module ipdfe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ipdfe_pkg::cmd_t push_cmd,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output ipdfe_pkg::cmd_t q_cmd
);
    import ipdfe_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign q_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/ipdfe_back.sv @@
// Symbol sequencer: expands a command into mark/space symbols, one per cycle
// while out_ready holds, into a registered output stage. Depends on ipdfe_pkg.
module ipdfe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipdfe_pkg::cfg_t      cfg,
    input  logic                 q_valid,
    input  ipdfe_pkg::cmd_t      q_cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ipdfe_pkg::out_item_t out_data
);
    import ipdfe_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_item_reg;
    out_item_t        sym;
    logic             emit;

    function automatic phase_t start_phase(input cmd_t c);
        phase_t p;
        if (c.start_of_frame && !c.second_frame)
        begin
            p = (WAKE_COUNT != 0) ? PH_WAKE : PH_TRAILER;
        end
        else if (c.start_of_frame)
        begin
            p = PH_HEADER;
        end
        else
        begin
            p = PH_DATA;
        end
        return p;
    endfunction

    assign emit      = (phase_reg != PH_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // symbol for the current phase
    always_comb
    begin
        sym.mark_ticks  = cfg.short_mark;
        sym.space_ticks = cfg.zero_space;
        sym.symbol_kind = K_WAKE;
        sym.last_of_run = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                sym.symbol_kind = K_WAKE;
            end
            PH_WAKE:
            begin
                sym.symbol_kind = K_WAKE;
            end
            PH_TRAILER:
            begin
                sym.space_ticks = cfg.wake_trailer_space;
                sym.symbol_kind = K_TRAILER;
            end
            PH_HEADER:
            begin
                sym.mark_ticks  = cfg.header_mark;
                sym.space_ticks = cfg.header_space;
                sym.symbol_kind = K_HEADER;
            end
            PH_DATA:
            begin
                sym.mark_ticks  = cfg.bit_mark;
                sym.space_ticks = cmd_reg.data_byte[cnt_reg] ? cfg.one_space : cfg.zero_space;
                sym.symbol_kind = K_DATA;
                sym.last_of_run = (cnt_reg == BIT_LAST) && !cmd_reg.end_of_frame;
            end
            PH_CHECK:
            begin
                sym.mark_ticks  = cfg.bit_mark;
                sym.space_ticks = cmd_reg.checksum[cnt_reg] ? cfg.one_space : cfg.zero_space;
                sym.symbol_kind = K_CHECK;
            end
            PH_END:
            begin
                sym.space_ticks = cmd_reg.second_frame ? cfg.zero_space : cfg.gap_space;
                sym.symbol_kind = K_END;
                sym.last_of_run = 1'b1;
            end
        endcase
    end

    // phase sequencing and queue pop
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        pop        = 1'b0;
        if (emit)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_WAKE:
                begin
                    if (cnt_reg == WAKE_LAST)
                    begin
                        phase_next = PH_TRAILER;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                PH_TRAILER:
                begin
                    phase_next = PH_HEADER;
                end
                PH_HEADER:
                begin
                    phase_next = PH_DATA;
                    cnt_next   = '0;
                end
                PH_DATA:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == BIT_LAST)
                    begin
                        phase_next = cmd_reg.end_of_frame ? PH_CHECK : PH_IDLE;
                    end
                end
                PH_CHECK:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == BIT_LAST)
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        if (q_valid && ((phase_reg == PH_IDLE) || (emit && sym.last_of_run)))
        begin
            pop        = 1'b1;
            cmd_next   = q_cmd;
            phase_next = start_phase(q_cmd);
            cnt_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            out_item_reg <= sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/ir_pulse_distance_frame_encoder.sv @@
// Top level of the pulse-distance IR frame encoder.
// Depends on ipdfe_pkg, ipdfe_cfg, ipdfe_front, ipdfe_queue, ipdfe_back.
//
//  channel  signals                          beat
//  in       in_valid  in_ready  in_data      one payload byte with frame flags
//  out      out_valid out_ready out_data     one mark/space symbol
//  cfg      cfg_valid cfg_ready cfg_index/data  one timing register write
//
// One symbol leaves per cycle while out_ready holds; a byte expands into 8 to 24
// symbols, set by the symbol sequencer in the back end.
// A two-entry command queue lets the front take bytes while symbols go out.
// Reset restores the default timings and clears the frame checksum.
// cfg_ready is always high.
module ir_pulse_distance_frame_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ipdfe_pkg::in_item_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ipdfe_pkg::out_item_t            out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipdfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipdfe_pkg::DUR_W-1:0]     cfg_data
);
    import ipdfe_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t q_cmd;
    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;

    ipdfe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipdfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    ipdfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    ipdfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
